// ===== src/lkv_pkg.sv =====
// Shared types, constants and widths for the LRU key-value cache.
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CAP_W       = 5;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RANK_W      = IDX_W;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_SET = 1'b1
	} op_t;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Search results handed from the lookup to the state update
	typedef struct packed {
		logic hit;
		idx_t hit_idx;
		logic evict;
		idx_t victim_idx;
		idx_t free_idx;
	} lkv_lookup_t;

endpackage

// ===== src/lkv_lookup.sv =====
// Parallel key match, victim select and free slot search over all entries.
`timescale 1ns / 1ps

module lkv_lookup (
	input  lkv_pkg::key_t        key,
	input  lkv_pkg::key_t        keys [lkv_pkg::MAX_ENTRIES],
	input  logic [lkv_pkg::MAX_ENTRIES-1:0] valid,
	input  lkv_pkg::rank_t       ranks [lkv_pkg::MAX_ENTRIES],
	input  lkv_pkg::cnt_t        count,
	input  lkv_pkg::cnt_t        eff_cap,
	output lkv_pkg::lkv_lookup_t res
);
	import lkv_pkg::*;

	cnt_t oldest_rank;

	assign oldest_rank = count - CNT_W'(1);

	always_comb begin
		res = '0;
		// evict when one more entry would pass the capacity
		res.evict = (count >= eff_cap);
		// keys are unique among valid entries, so OR-ing indices is a mux
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (valid[i] && keys[i] == key) begin
				res.hit     = 1'b1;
				res.hit_idx = res.hit_idx | IDX_W'(i);
			end
			// ranks form 0..count-1, so the oldest entry is unique
			if (valid[i] && CNT_W'(ranks[i]) == oldest_rank) begin
				res.victim_idx = res.victim_idx | IDX_W'(i);
			end
		end
		// lowest free slot once the victim is gone
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!valid[i] || (res.evict && res.victim_idx == IDX_W'(i))) begin
				res.free_idx = IDX_W'(i);
			end
		end
	end

endmodule

// ===== src/lkv_store.sv =====
// Entry table: keys, values, valid bits, recency ranks and the fill count.
`timescale 1ns / 1ps

module lkv_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lkv_pkg::cnt_t        eff_cap,
	input  logic                 upd,
	input  lkv_pkg::op_t         op,
	input  lkv_pkg::key_t        key,
	input  lkv_pkg::val_t        value,
	output lkv_pkg::val_t        read_value,
	output logic                 hit
);
	import lkv_pkg::*;

	key_t                   keys_q   [MAX_ENTRIES];
	val_t                   values_q [MAX_ENTRIES];
	rank_t                  ranks_q  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	cnt_t                   count_q;
	lkv_lookup_t            lk;
	rank_t                  old_rank;
	logic                   do_set;

	lkv_lookup u_lookup (
		.key     (key),
		.keys    (keys_q),
		.valid   (valid_q),
		.ranks   (ranks_q),
		.count   (count_q),
		.eff_cap (eff_cap),
		.res     (lk)
	);

	assign do_set     = upd && (op == OP_SET);
	assign old_rank   = ranks_q[lk.hit_idx];
	assign hit        = lk.hit;
	assign read_value = lk.hit ? values_q[lk.hit_idx] : MISS_VALUE;

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (do_set) begin
			if (lk.hit) begin
				values_q[lk.hit_idx] <= value;
			end else begin
				keys_q[lk.free_idx]   <= key;
				values_q[lk.free_idx] <= value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				ranks_q[i] <= '0;
			end
		end else if (do_set) begin
			if (lk.hit) begin
				// move to front: younger entries age by one
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (lk.hit_idx == IDX_W'(i)) begin
						ranks_q[i] <= '0;
					end else if (valid_q[i] && ranks_q[i] < old_rank) begin
						ranks_q[i] <= ranks_q[i] + RANK_W'(1);
					end
				end
			end else begin
				// free slot is either empty or the victim being dropped
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (lk.free_idx == IDX_W'(i)) begin
						valid_q[i] <= 1'b1;
						ranks_q[i] <= '0;
					end else if (lk.evict && lk.victim_idx == IDX_W'(i)) begin
						valid_q[i] <= 1'b0;
						ranks_q[i] <= '0;
					end else if (valid_q[i]) begin
						ranks_q[i] <= ranks_q[i] + RANK_W'(1);
					end
				end
				if (!lk.evict) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

// ===== src/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: input stage, table and result register.
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-set replacement.
// Input channel (in_valid / in_stall) carries one beat per op: a get
// (op = 0) looks up key, a set (op = 1) writes value under key. A set
// gives no result beat; a get gives one on the output channel
// (out_valid / out_stall) with read_value and hit, or all-ones and hit
// clear on a miss. Gets never change recency.
// Path: a get's input beat is captured in the input register, and its
// result is captured in the result register once that register is free
// (empty or being taken); the result beat is then offered on out_valid.
// Throughput is one beat per cycle while no get waits on a stalled result:
// the 16-entry table is searched by a parallel compare and updated in the
// same cycle the op leaves the input register.
// Stall: while out_stall holds a pending result, a get waiting in the
// input register stays there and in_stall rises; sets still drain.
// cfg_we / cfg_wdata write the capacity (reset 16). Zero acts as one,
// values above the table size act as the table size. Write it only
// while the cache is idle.
// Reset (arst_n low) empties the table and drops any beat in flight.

module lru_key_value_cache (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic signed [lkv_pkg::KEY_W-1:0] key,
	input  logic signed [lkv_pkg::VAL_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [lkv_pkg::VAL_W-1:0] read_value,
	output logic                     hit
);
	import lkv_pkg::*;

	logic [CAP_W-1:0] cap_q;
	cnt_t             eff_cap;

	// input stage
	logic             valid_s1;
	op_t              op_s1;
	key_t             key_s1;
	val_t             value_s1;

	// result stage
	logic             out_valid_q;
	val_t             read_value_q;
	logic             hit_q;

	logic             out_free;
	logic             fire;
	val_t             lk_value;
	logic             lk_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// clamp capacity to 1..MAX_ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (32'(cap_q) > MAX_ENTRIES) begin
			eff_cap = CNT_W'(MAX_ENTRIES);
		end else begin
			eff_cap = CNT_W'(cap_q);
		end
	end

	// result slot is free if empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	// sets need no result slot, gets do
	assign fire     = valid_s1 && (op_s1 == OP_SET || out_free);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1    <= op_t'(op);
			key_s1   <= key_t'(key);
			value_s1 <= val_t'(value);
		end
	end

	lkv_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.eff_cap    (eff_cap),
		.upd        (fire),
		.op         (op_s1),
		.key        (key_s1),
		.value      (value_s1),
		.read_value (lk_value),
		.hit        (lk_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && (op_s1 == OP_GET);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && op_s1 == OP_GET) begin
			read_value_q <= lk_value;
			hit_q        <= lk_hit;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign hit        = hit_q;

endmodule
